// ===== sv/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants for the tile record subdivider
// Holds the configuration, queue entry and result layouts, the error and
// register codes, and the fixed sizes of the subdivision datapath.
// ----------------------------------------------------------------------------
package trs_pkg;

  // Largest number of subdivisions per axis; larger settings saturate here.
  localparam int MAX_SUBTILES = 8;
  // Fraction bits of the subregion offsets.
  localparam int FRAC_BITS    = 8;
  // Width of the emitted grid coordinates.
  localparam int TILE_W       = 12;
  // Width of a scaled image size, pixels with fraction bits appended.
  localparam int POS_W        = 16 + FRAC_BITS;

  localparam int IN_W         = 128;
  localparam int CFG_DATA_W   = 31;
  localparam int CFG_IDX_W    = 3;

  // Error codes carried on the result channel.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NEG_OFFSET = 2'd1;
  localparam logic [1:0] ERR_BAD_LENGTH = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_DIVISIONS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTILES_PER_SIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH_PX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT_PX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ENTRIES      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD_LENGTH = 3'd7;

  typedef struct packed {
    logic [12:0] grid_columns;
    logic [12:0] grid_rows;
    logic [8:0]  camera_divisions;
    logic [3:0]  subtiles_per_side;
    logic [15:0] image_width_px;
    logic [15:0] image_height_px;
    logic [24:0] gain_entries;
    logic [30:0] max_record_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    grid_columns:      13'd1,
    grid_rows:         13'd1,
    camera_divisions:  9'd1,
    subtiles_per_side: 4'd1,
    image_width_px:    16'd1,
    image_height_px:   16'd1,
    gain_entries:      25'd0,
    max_record_length: 31'h7fff_ffff
  };

  // A classified record as it sits in the queue.
  typedef struct packed {
    logic [1:0]  code;
    logic [30:0] num;
    logic [30:0] off;
    logic [30:0] len;
    logic [31:0] fno;
  } rec_t;

  // Result beat payload, last member in the lowest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic              gain_valid;
    logic [23:0]       gain_index;
    logic [31:0]       file_number_out;
    logic [30:0]       length_out;
    logic [30:0]       offset_out;
    logic [30:0]       image_number_out;
    logic [23:0]       sub_y_fixed;
    logic [23:0]       sub_x_fixed;
    logic [TILE_W-1:0] tile_row;
    logic [TILE_W-1:0] tile_col;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// ===== sv/trs_front.sv =====
// ----------------------------------------------------------------------------
// trs_front: record intake and validation
// Unpacks an input beat, checks offset and length in priority order and
// pushes the classified record into the work queue.
// ----------------------------------------------------------------------------
module trs_front
  import trs_pkg::*;
(
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic [30:0]     max_record_length,
  input  logic            q_full,
  output logic            q_push,
  output rec_t            q_rec
);

  logic [31:0] off;
  logic [31:0] len;

  assign off = in_tdata[62:31];
  assign len = in_tdata[94:63];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_rec.num = in_tdata[30:0];
    q_rec.off = off[30:0];
    q_rec.len = len[30:0];
    q_rec.fno = in_tdata[126:95];
    // The offset is checked first, then the length sign and zero, then its size.
    if (off[31]) begin
      q_rec.code = ERR_NEG_OFFSET;
    end else if (len[31] || (len == 32'd0)) begin
      q_rec.code = ERR_BAD_LENGTH;
    end else if (len[30:0] > max_record_length) begin
      q_rec.code = ERR_TOO_LONG;
    end else begin
      q_rec.code = ERR_NONE;
    end
  end

endmodule

// ===== sv/trs_fifo.sv =====
// ----------------------------------------------------------------------------
// trs_fifo: short record queue
// A small register queue that lets the front and back run independently.
// ----------------------------------------------------------------------------
module trs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [IW-1:0] wr_ptr_r;
  logic [IW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== sv/trs_div.sv =====
// ----------------------------------------------------------------------------
// trs_div: restoring serial divider
// Produces one quotient bit per cycle while busy is high, and the results
// hold until the next start.
// ----------------------------------------------------------------------------
module trs_div #(
  parameter int DW = 8,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          take;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], take};
      rem_r <= take ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

// ===== sv/trs_back.sv =====
// ----------------------------------------------------------------------------
// trs_back: subdivision sequencer and result register
// Takes classified records from the queue, splits the image index into grid
// column and row, and walks the subtiles one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module trs_back
  import trs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  rec_t             q_rec,
  output logic             q_pop,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [RES_W-1:0] out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_TILE = 3'd4;

  logic [2:0]  state_r;
  logic [2:0]  state_nxt;

  logic [12:0] cols_eff;
  logic [8:0]  div_eff;
  logic [3:0]  subs_eff;

  rec_t        rec_r;

  // Divider results.
  logic              num_busy;
  logic [30:0]       num_quo;
  logic [12:0]       num_rem;
  logic              cd_busy;
  logic [12:0]       cd_quo;
  logic              w_busy;
  logic [POS_W-1:0]  w_quo;
  logic [3:0]        w_rem;
  logic              h_busy;
  logic [POS_W-1:0]  h_quo;
  logic [3:0]        h_rem;
  logic              gx_busy;
  logic [12:0]       gx_quo;
  logic              gy_busy;
  logic [12:0]       gy_quo;

  logic start1;
  logic start2;
  logic div1_done;
  logic div2_done;
  logic outside;

  // Subtile walk.
  logic [3:0]        sx_r;
  logic [3:0]        sy_r;
  logic [13:0]       tx_r;
  logic [13:0]       ty_r;
  logic [POS_W-1:0]  qx_r;
  logic [3:0]        rx_r;
  logic [POS_W-1:0]  qy_r;
  logic [3:0]        ry_r;
  logic [26:0]       rb_r;

  logic [3:0]        sx_inc;
  logic [3:0]        sy_inc;
  logic [14:0]       tx_step;
  logic [14:0]       ty_step;
  logic              col_more;
  logic              row_more;
  logic [3:0]        rx_sum;
  logic [3:0]        ry_sum;
  logic              rx_wrap;
  logic              ry_wrap;
  logic [27:0]       gi;
  logic              ge_nz;

  // Output register.
  logic              out_valid_r;
  res_t              res_r;
  logic [1:0]        code_r;
  logic              last_r;
  res_t              res_nxt;
  logic [1:0]        code_nxt;
  logic              last_nxt;
  logic              ld;
  logic              slot_free;

  assign cols_eff = (cfg.grid_columns == '0) ? 13'd1 : cfg.grid_columns;
  assign div_eff  = (cfg.camera_divisions == '0) ? 9'd1 : cfg.camera_divisions;
  assign subs_eff = (cfg.subtiles_per_side > 4'(MAX_SUBTILES)) ?
                    4'(MAX_SUBTILES) : cfg.subtiles_per_side;

  assign slot_free = !out_valid_r || out_tready;

  assign start1    = q_pop && (q_rec.code == ERR_NONE);
  assign div1_done = !num_busy && !cd_busy && !w_busy && !h_busy;
  assign outside   = (num_quo >= {18'd0, cfg.grid_rows});
  assign start2    = (state_r == ST_DIV1) && div1_done && !outside && (subs_eff != '0);
  assign div2_done = !gx_busy && !gy_busy;

  trs_div #(.DW(31), .VW(13)) u_div_num (
    .clk(clk), .rst_n(rst_n), .start(start1), .dividend(q_rec.num),
    .divisor(cols_eff), .busy(num_busy), .quo(num_quo), .rem(num_rem)
  );

  trs_div #(.DW(13), .VW(9)) u_div_cd (
    .clk(clk), .rst_n(rst_n), .start(start1), .dividend(cols_eff),
    .divisor(div_eff), .busy(cd_busy), .quo(cd_quo), .rem()
  );

  trs_div #(.DW(POS_W), .VW(4)) u_div_w (
    .clk(clk), .rst_n(rst_n), .start(start1),
    .dividend({cfg.image_width_px, FRAC_BITS'(0)}),
    .divisor(subs_eff), .busy(w_busy), .quo(w_quo), .rem(w_rem)
  );

  trs_div #(.DW(POS_W), .VW(4)) u_div_h (
    .clk(clk), .rst_n(rst_n), .start(start1),
    .dividend({cfg.image_height_px, FRAC_BITS'(0)}),
    .divisor(subs_eff), .busy(h_busy), .quo(h_quo), .rem(h_rem)
  );

  trs_div #(.DW(13), .VW(9)) u_div_gx (
    .clk(clk), .rst_n(rst_n), .start(start2), .dividend(num_rem),
    .divisor(div_eff), .busy(gx_busy), .quo(gx_quo), .rem()
  );

  trs_div #(.DW(13), .VW(9)) u_div_gy (
    .clk(clk), .rst_n(rst_n), .start(start2), .dividend(num_quo[12:0]),
    .divisor(div_eff), .busy(gy_busy), .quo(gy_quo), .rem()
  );

  // Next step along the row and down the columns.
  assign sx_inc   = sx_r + 4'd1;
  assign sy_inc   = sy_r + 4'd1;
  assign tx_step  = {1'b0, tx_r} + {6'd0, div_eff};
  assign ty_step  = {1'b0, ty_r} + {6'd0, div_eff};
  assign col_more = (sx_inc < subs_eff) && (tx_step < {2'd0, cols_eff});
  assign row_more = (sy_inc < subs_eff) && (ty_step < {2'd0, cfg.grid_rows});

  // Offsets advance by quotient and remainder of size/subs, with carry.
  assign rx_sum  = rx_r + w_rem;
  assign ry_sum  = ry_r + h_rem;
  assign rx_wrap = (rx_sum >= subs_eff);
  assign ry_wrap = (ry_sum >= subs_eff);

  assign gi    = {1'b0, rb_r} + {15'd0, gx_quo} + {24'd0, sx_r};
  assign ge_nz = (cfg.gain_entries != '0);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ld        = 1'b0;
    res_nxt   = '0;
    code_nxt  = ERR_NONE;
    last_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = (q_rec.code != ERR_NONE) ? ST_ERR : ST_DIV1;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          ld                       = 1'b1;
          code_nxt                 = rec_r.code;
          res_nxt.image_number_out = rec_r.num;
          last_nxt                 = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      ST_DIV1: begin
        if (div1_done) begin
          state_nxt = (outside || (subs_eff == '0)) ? ST_IDLE : ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div2_done) begin
          state_nxt = ST_TILE;
        end
      end
      ST_TILE: begin
        if (slot_free) begin
          ld                       = 1'b1;
          res_nxt.tile_col         = tx_r[TILE_W-1:0];
          res_nxt.tile_row         = ty_r[TILE_W-1:0];
          res_nxt.sub_x_fixed      = qx_r;
          res_nxt.sub_y_fixed      = qy_r;
          res_nxt.image_number_out = rec_r.num;
          res_nxt.offset_out       = rec_r.off;
          res_nxt.length_out       = rec_r.len;
          res_nxt.file_number_out  = rec_r.fno;
          res_nxt.gain_index       = ge_nz ? gi[23:0] : 24'd0;
          res_nxt.gain_valid       = ge_nz && ({3'd0, cfg.gain_entries} > gi);
          last_nxt                 = !col_more && !row_more;
          if (!col_more && !row_more) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_rec;
    end
    if (ld) begin
      res_r  <= res_nxt;
      code_r <= code_nxt;
      last_r <= last_nxt;
    end
    if ((state_r == ST_DIV2) && div2_done) begin
      rb_r <= {14'd0, gy_quo} * {14'd0, cd_quo};
      sx_r <= '0;
      sy_r <= '0;
      tx_r <= {1'b0, num_rem};
      ty_r <= {1'b0, num_quo[12:0]};
      qx_r <= '0;
      rx_r <= '0;
      qy_r <= '0;
      ry_r <= '0;
    end else if ((state_r == ST_TILE) && slot_free) begin
      if (col_more) begin
        sx_r <= sx_inc;
        tx_r <= tx_step[13:0];
        qx_r <= qx_r + w_quo + {{(POS_W-1){1'b0}}, rx_wrap};
        rx_r <= rx_wrap ? rx_sum - subs_eff : rx_sum;
      end else if (row_more) begin
        sx_r <= '0;
        tx_r <= {1'b0, num_rem};
        qx_r <= '0;
        rx_r <= '0;
        sy_r <= sy_inc;
        ty_r <= ty_step[13:0];
        qy_r <= qy_r + h_quo + {{(POS_W-1){1'b0}}, ry_wrap};
        ry_r <= ry_wrap ? ry_sum - subs_eff : ry_sum;
        rb_r <= rb_r + {14'd0, cd_quo};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign out_tuser  = code_r;
  assign out_tlast  = last_r;

endmodule

// ===== sv/tile_record_subdivider.sv =====
// ----------------------------------------------------------------------------
// tile_record_subdivider: index record validation and subtile expansion
// Checks a stored-image index record and expands it into subtile beats.
// ----------------------------------------------------------------------------
//   Input channel (in_*): one beat is one index record. A front stage checks
//   it at once and places it in a short queue, so in_tready stays high
//   until the queue is full.
//   Result channel (out_*): a failed check gives one error beat, with the
//   error code on out_tuser and out_tlast set. A valid record gives one beat
//   per subtile, row by row, with out_tlast on the final one; a record whose
//   grid row lies beyond the slide, or a zero subtile count, gives no beat.
//   Configuration (cfg_*): one register per write, taken on any edge with
//   cfg_wr_en high; write it only while no record is in flight.
//   An error beat passes through the queue and the error state into the
//   output register. A valid record passes through the queue, divides its
//   index by the grid width and tests the row bound, then divides the grid
//   position by the camera divisions, then gives one subtile per cycle
//   while the result register is free, up to 64 in all. The next record
//   leaves the queue while the last beat waits in the output register.
//   rst_n is synchronous and active low; it empties the queue, drops any
//   pending beat and restores the configuration registers to CFG_RESET.
//   While out_tready is low the result register holds its beat, the walk
//   pauses, and the queue then fills and drops in_tready.
// ----------------------------------------------------------------------------
module tile_record_subdivider
  import trs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, from bit 0: image_number[30:0], byte_offset[62:31],
  // byte_length[94:63], file_number[126:95], zero pad[127]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  // out_tdata, from bit 0: tile_col[11:0], tile_row[23:12],
  // sub_x_fixed[47:24], sub_y_fixed[71:48], image_number_out[102:72],
  // offset_out[133:103], length_out[164:134], file_number_out[196:165],
  // gain_index[220:197], gain_valid[221], zero pad[223:222]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [RES_W-1:0]      out_tdata,
  // out_tuser: error_code[1:0]
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  rec_t q_in;
  rec_t q_out;

  // Configuration registers; each write keeps only its register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_COLUMNS:      cfg_r.grid_columns      <= cfg_data[12:0];
        REG_GRID_ROWS:         cfg_r.grid_rows         <= cfg_data[12:0];
        REG_CAMERA_DIVISIONS:  cfg_r.camera_divisions  <= cfg_data[8:0];
        REG_SUBTILES_PER_SIDE: cfg_r.subtiles_per_side <= cfg_data[3:0];
        REG_IMAGE_WIDTH_PX:    cfg_r.image_width_px    <= cfg_data[15:0];
        REG_IMAGE_HEIGHT_PX:   cfg_r.image_height_px   <= cfg_data[15:0];
        REG_GAIN_ENTRIES:      cfg_r.gain_entries      <= cfg_data[24:0];
        REG_MAX_RECORD_LENGTH: cfg_r.max_record_length <= cfg_data[30:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Front: accept and classify records.
  trs_front u_front (
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .max_record_length (cfg_r.max_record_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_rec             (q_in)
  );

  // Queue between the two halves.
  trs_fifo #(
    .W     ($bits(rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // Back: divide, walk the subtiles and drive the result register.
  trs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_rec      (q_out),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/trs_checker.sv =====
// ----------------------------------------------------------------------------
// trs_checker: port-level checks for the tile record subdivider
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module trs_checker
  import trs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [RES_W-1:0] out_tdata,
  input logic [1:0]       out_tuser,
  input logic             out_tlast
);

  // A stalled beat stays valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // An error record always ends in one beat with cleared tile fields.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ERR_NONE) |->
      out_tlast && (out_tdata[71:0] == '0) && (out_tdata[223:103] == '0))
    else $error("error beat not final or carries tile data");

  // Reset leaves the result channel quiet.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind tile_record_subdivider trs_checker u_trs_checker (.*);

// ===== tb/tb_tile_record_subdivider.sv =====
// ----------------------------------------------------------------------------
// tb_tile_record_subdivider: self-checking bench for the tile record subdivider
// Sends index records over the input stream and predicts every subtile beat
// and error beat that each record should produce from the current slide
// setup. A directed part covers the record checks, the slide corners and the
// register corner cases, then random records run under several random
// setups, mostly while both stream sides idle at random. One stretch holds the
// result side off long enough for the block to fill and stall its input.
// ----------------------------------------------------------------------------
module tb_tile_record_subdivider;
  import trs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A record with no beats (outside the slide, or no subtiles) can still be
  // in the divider when the last expected beat arrives. Up to three records
  // can sit in the queue and the walker, each passing the first divide
  // before it is known to make no beat.
  localparam int DRAIN_CYCLES   = 300;
  // How long the result side refuses beats during the backpressure test.
  localparam int HOLD_CYCLES    = 400;
  // Cycles without any accepted beat on either side before giving up.
  localparam int WATCHDOG_LIMIT = 4000;

  // One predicted result beat: side-band code, last flag and the payload.
  typedef struct packed {
    logic [1:0] code;
    logic       last;
    res_t       beat;
  } tile_expect_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [RES_W-1:0]      out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the slide setup, updated alongside every register write.
  cfg_t         slide_cfg = CFG_RESET;
  tile_expect_t pending_tiles[$];

  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned quiet_cycles   = 0;

  tile_record_subdivider dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Subregion offset of step number idx out of parts, in pixels with
  // FRAC_BITS fraction bits, truncated and saturated to 24 bits.
  function automatic logic [23:0] offset_fixed(bit [63:0] size, bit [63:0] idx,
                                               bit [63:0] parts);
    bit [63:0] v;
    v = ((size * idx) << FRAC_BITS) / parts;
    return (v > 64'hff_ffff) ? 24'hff_ffff : v[23:0];
  endfunction

  // Appends one predicted beat behind the ones already waiting.
  function automatic void queue_beat(input tile_expect_t t);
    pending_tiles = {pending_tiles, t};
  endfunction

  // Works out every beat that one accepted record causes under slide_cfg and
  // appends them, in order, to pending_tiles.
  function automatic void expand_record(bit [30:0] num, bit [31:0] off,
                                        bit [31:0] len, bit [31:0] fno);
    tile_expect_t t;
    tile_expect_t prev;
    bit           have_prev;
    bit [63:0]    cols, rows, step, subs, limit, gains;
    bit [63:0]    gx, gy, tx, ty, gi, sx, sy;
    t = '0;
    prev = '0;
    have_prev = 1'b0;
    limit = slide_cfg.max_record_length;
    // The checks are ordered; only the first failing one is reported.
    if (off[31])
      t.code = ERR_NEG_OFFSET;
    else if (len[31] || len == 32'd0)
      t.code = ERR_BAD_LENGTH;
    else if (len > limit)
      t.code = ERR_TOO_LONG;
    if (t.code != ERR_NONE) begin
      t.beat.image_number_out = num;
      t.last = 1'b1;
      queue_beat(t);
      return;
    end

    // Zero divisors act as one; the subtile count saturates.
    cols  = (slide_cfg.grid_columns == 0) ? 64'd1 : slide_cfg.grid_columns;
    step  = (slide_cfg.camera_divisions == 0) ? 64'd1 : slide_cfg.camera_divisions;
    subs  = (slide_cfg.subtiles_per_side > MAX_SUBTILES) ? MAX_SUBTILES
                                                         : slide_cfg.subtiles_per_side;
    rows  = slide_cfg.grid_rows;
    gains = slide_cfg.gain_entries;
    gx = num % cols;
    gy = num / cols;

    for (sy = 0; sy < subs && gy + sy * step < rows; sy++) begin
      ty = gy + sy * step;
      for (sx = 0; sx < subs && gx + sx * step < cols; sx++) begin
        tx = gx + sx * step;
        t = '0;
        t.beat.tile_col         = tx[TILE_W-1:0];
        t.beat.tile_row         = ty[TILE_W-1:0];
        t.beat.sub_x_fixed      = offset_fixed(slide_cfg.image_width_px, sx, subs);
        t.beat.sub_y_fixed      = offset_fixed(slide_cfg.image_height_px, sy, subs);
        t.beat.image_number_out = num;
        t.beat.offset_out       = off[30:0];
        t.beat.length_out       = len[30:0];
        t.beat.file_number_out  = fno;
        // The valid flag is judged on the full index, before masking.
        if (gains != 0) begin
          gi = (ty / step) * (cols / step) + tx / step;
          t.beat.gain_index = gi[23:0];
          t.beat.gain_valid = (gi < gains);
        end
        if (have_prev)
          queue_beat(prev);
        prev = t;
        have_prev = 1'b1;
      end
    end
    if (have_prev) begin
      prev.last = 1'b1;
      queue_beat(prev);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // One register write per clock; the enable stays high across a burst and
  // is dropped by apply_setting once the burst is over.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic apply_setting(input int unsigned cols, input int unsigned rows,
                               input int unsigned step, input int unsigned subs,
                               input int unsigned width, input int unsigned height,
                               input int unsigned gains, input int unsigned limit);
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_CAMERA_DIVISIONS, step);
    write_reg(REG_SUBTILES_PER_SIDE, subs);
    write_reg(REG_IMAGE_WIDTH_PX, width);
    write_reg(REG_IMAGE_HEIGHT_PX, height);
    write_reg(REG_GAIN_ENTRIES, gains);
    write_reg(REG_MAX_RECORD_LENGTH, limit);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    // Assignment to the packed fields truncates to the register widths.
    slide_cfg.grid_columns      = cols;
    slide_cfg.grid_rows         = rows;
    slide_cfg.camera_divisions  = step;
    slide_cfg.subtiles_per_side = subs;
    slide_cfg.image_width_px    = width;
    slide_cfg.image_height_px   = height;
    slide_cfg.gain_entries      = gains;
    slide_cfg.max_record_length = limit;
  endtask

  // Offers one record and returns in the time step of the edge that took it.
  // Valid stays high when the next record follows without a gap.
  task automatic send_record(input bit [30:0] num, input bit [31:0] off,
                             input bit [31:0] len, input bit [31:0] fno);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, fno, len, off, num};
    do
      @(posedge clk);
    while (!in_tready);
    expand_record(num, off, len, fno);
  endtask

  // Stops offering, waits for every predicted beat, then lets any trailing
  // beatless records leave the block before the setup may change.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_tiles.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly records that land on the slide with a valid length, plus offsets
  // and lengths that fail each check and indexes beyond the slide.
  task automatic send_random_record();
    int unsigned span, limit, pick;
    bit [30:0]   num;
    bit [31:0]   off, len;
    span  = slide_cfg.grid_columns * slide_cfg.grid_rows;
    limit = slide_cfg.max_record_length;
    pick  = $urandom_range(0, 99);
    if (pick < 85)
      num = $urandom_range(0, span - 1);
    else if (pick < 90)
      num = span + $urandom_range(0, 20);
    else
      num = $urandom;
    off = $urandom;
    off[31] = ($urandom_range(0, 99) >= 85);
    case ($urandom_range(0, 9))
      0: len = 32'd0;
      1: begin
        len = $urandom;
        len[31] = 1'b1;
      end
      2: len = (limit < 32'h7fff_ffff) ? $urandom_range(limit + 1, 32'h7fff_ffff)
                                       : 32'h7fff_ffff;
      default: len = $urandom_range(1, limit);
    endcase
    send_record(num, off, len, $urandom);
  endtask

  // Setups within the documented ranges, biased toward small grids so that
  // records mostly land on the slide and rows and columns get clipped.
  task automatic random_setting();
    int unsigned cols, rows, step, gains, limit;
    cols = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(1, 4096);
    rows = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(1, 4096);
    step = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 3) : $urandom_range(1, 256);
    case ($urandom_range(0, 3))
      0: gains = 0;
      1: gains = $urandom_range(1, 24);
      2: gains = $urandom_range(1, 4096);
      default: gains = $urandom_range(1, 32'h0100_0000);
    endcase
    limit = ($urandom_range(0, 1) == 1) ? 32'h7fff_ffff : $urandom_range(1, 32'h00ff_ffff);
    apply_setting(cols, rows, step, $urandom_range(1, 8), $urandom_range(1, 65535),
                  $urandom_range(1, 65535), gains, limit);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers at their reset values: a one-cell slide with one subtile.
  task automatic test_reset_defaults();
    send_record(31'd0, 32'd0, 32'd16, 32'd3);
    send_record(31'd1, 32'd0, 32'd16, 32'd3);   // row 1 is off the slide
  endtask

  // Each record check, their order, and the largest values that still pass.
  task automatic test_record_checks();
    settle();
    apply_setting(4, 4, 1, 2, 640, 480, 16, 1000);
    send_record(31'd7, 32'hffff_ffff, 32'd100, 32'd1);
    send_record(31'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd2);  // offset wins
    send_record(31'd2, 32'd0, 32'd0, 32'd3);
    send_record(31'd3, 32'd5, 32'hffff_fffb, 32'd4);
    send_record(31'd4, 32'd5, 32'h8000_0000, 32'd5);
    send_record(31'd5, 32'd5, 32'd1001, 32'd6);
    send_record(31'd0, 32'h7fff_ffff, 32'd1000, 32'h8000_0000);
    send_record(31'd15, 32'd0, 32'd1, 32'h7fff_ffff);
  endtask

  // The widest documented slide: 64 subtiles, the far corner, and the first
  // index past the end.
  task automatic test_full_grid();
    settle();
    apply_setting(4096, 4096, 256, 8, 65535, 65535, 32'h0100_0000, 32'h7fff_ffff);
    send_record(31'd0, 32'd0, 32'h7fff_ffff, 32'd9);
    send_record(31'd4095, 32'd1, 32'h7fff_ffff, 32'd9);
    send_record(31'd16777215, 32'd2, 32'd1, 32'd9);
    send_record(31'd16777216, 32'd3, 32'd1, 32'd9);
  endtask

  // A small slide that clips both axes and leaves some gain indexes out.
  task automatic test_edge_clipping();
    settle();
    apply_setting(5, 3, 2, 3, 100, 37, 3, 32'h7fff_ffff);
    send_record(31'd0, 32'd10, 32'd20, 32'd30);
    send_record(31'd8, 32'd10, 32'd20, 32'd30);
  endtask

  // Register corners: zero divisors, a zero length limit, a subtile count
  // above the maximum, zero subtiles, and a grid so large that the gain
  // index overflows 24 bits and the grid coordinates wrap.
  task automatic test_register_corners();
    settle();
    apply_setting(0, 2, 0, 15, 65535, 1, 1, 0);
    send_record(31'd0, 32'd0, 32'd1, 32'd1);
    settle();
    apply_setting(0, 2, 0, 15, 65535, 65535, 1, 32'h7fff_ffff);
    send_record(31'd0, 32'd0, 32'd1, 32'd1);
    send_record(31'd1, 32'd0, 32'd1, 32'd1);
    settle();
    apply_setting(3, 3, 1, 0, 100, 100, 0, 32'h7fff_ffff);
    send_record(31'd0, 32'd0, 32'd1, 32'd1);
    settle();
    apply_setting(8191, 8191, 1, 8, 1000, 1000, 32'h01ff_ffff, 32'h7fff_ffff);
    send_record(31'(4000 * 8191 + 8185), 32'd0, 32'd64, 32'd1);
    send_record(31'(8190 * 8191), 32'd0, 32'd64, 32'd1);
  endtask

  // The result side refuses beats for a long stretch while records keep
  // coming, so the queue fills and the input must stall without loss.
  task automatic test_output_backpressure();
    settle();
    apply_setting(8, 8, 1, 2, 256, 256, 64, 32'h7fff_ffff);
    hold_req = 1'b1;
    repeat (12)
      send_record($urandom_range(0, 63), $urandom_range(0, 4096), $urandom_range(1, 4096),
                  $urandom);
  endtask

  task automatic test_random_records(input int unsigned setups, input int unsigned per_setup);
    repeat (setups) begin
      settle();
      random_setting();
      repeat (per_setup)
        send_random_record();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready pattern, checking and watchdog
  // --------------------------------------------------------------------------

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: beat %0d %s expected %0h got %0h", $realtime, results_seen, name,
                 want, got);
    end
  endtask

  task automatic check_result();
    tile_expect_t want;
    res_t         got;
    got = out_tdata;
    results_seen++;
    if (pending_tiles.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: beat %0d arrived with nothing expected", $realtime, results_seen);
      return;
    end
    want = pending_tiles.pop_front();
    check_field("error_code", want.code, out_tuser);
    check_field("last", want.last, out_tlast);
    check_field("tile_col", want.beat.tile_col, got.tile_col);
    check_field("tile_row", want.beat.tile_row, got.tile_row);
    check_field("sub_x_fixed", want.beat.sub_x_fixed, got.sub_x_fixed);
    check_field("sub_y_fixed", want.beat.sub_y_fixed, got.sub_y_fixed);
    check_field("image_number_out", want.beat.image_number_out, got.image_number_out);
    check_field("offset_out", want.beat.offset_out, got.offset_out);
    check_field("length_out", want.beat.length_out, got.length_out);
    check_field("file_number_out", want.beat.file_number_out, got.file_number_out);
    check_field("gain_index", want.beat.gain_index, got.gain_index);
    check_field("gain_valid", want.beat.gain_valid, got.gain_valid);
    check_field("pad", want.beat.pad, got.pad);
  endtask

  // Values read here are the ones present just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_result();
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** tile_record_subdivider: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with a lightly gapped sender and a slow receiver.
    src_gap_pct    = 13;
    sink_stall_pct = 47;
    test_reset_defaults();
    test_record_checks();
    test_full_grid();
    test_edge_clipping();
    test_register_corners();
    test_random_records(4, 26);

    // Roles swapped: a gappy sender and a mostly ready receiver.
    src_gap_pct    = 47;
    sink_stall_pct = 13;
    test_random_records(4, 26);

    // Both sides at full rate.
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_output_backpressure();
    test_random_records(4, 26);

    settle();
    if (mismatches == 0)
      $display("** tile_record_subdivider: PASSED **");
    else
      $display("** tile_record_subdivider: FAILED **");
    $finish;
  end

endmodule
